/* hdl/hvps_pkg.sv */
// Shared types, codes and constants for the HV precharge safety sequencer.
// No dependencies; every other file refers to this package by scoped names.
package hvps_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int MODE_W  = 4;
    localparam int CC_W    = 2;
    localparam int CFG_W   = 16;

    // Defaults
    localparam int TIMER_BITS_DEFAULT = 16;
    localparam logic [CFG_W-1:0] PRECHARGE_RESET_TICKS = 16'd500;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EVALUATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FAULT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ENABLE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;

    // Sequencer states
    localparam logic [MODE_W-1:0] ST_INIT            = 4'd0;
    localparam logic [MODE_W-1:0] ST_HARD_ERROR      = 4'd1;
    localparam logic [MODE_W-1:0] ST_ERROR           = 4'd2;
    localparam logic [MODE_W-1:0] ST_WAIT_SAFETY     = 4'd3;
    localparam logic [MODE_W-1:0] ST_WAIT_LOOP       = 4'd4;
    localparam logic [MODE_W-1:0] ST_WAIT_SHUTDOWN   = 4'd5;
    localparam logic [MODE_W-1:0] ST_WAIT_ACTIVATION = 4'd6;
    localparam logic [MODE_W-1:0] ST_PRECHARGING     = 4'd7;
    localparam logic [MODE_W-1:0] ST_TIMED           = 4'd8;
    localparam logic [MODE_W-1:0] ST_READY           = 4'd9;

    // Contactor commands
    localparam logic [CC_W-1:0] CC_OPEN      = 2'd0;
    localparam logic [CC_W-1:0] CC_PRECHARGE = 2'd1;
    localparam logic [CC_W-1:0] CC_RUN       = 2'd2;

    // Status bits sampled with an evaluate request
    typedef struct packed {
        logic bms_ok;
        logic stack_plausible;
        logic insulation_ok;
        logic disconnects_ok;
        logic contactor_power_ok;
        logic precharge_reached;
        logic precharge_in_range;
    } status_t;

endpackage

/* hdl/hvps_decide.sv */
// Next-state decision logic of the precharge sequencer, one request per call.
// Depends on hvps_pkg for codes, widths and the status struct.
module hvps_decide #(
    parameter int TIMER_BITS = hvps_pkg::TIMER_BITS_DEFAULT
) (
    input  logic [hvps_pkg::CMD_W-1:0]  cmd,
    input  logic                        enable_request,
    input  hvps_pkg::status_t           status,
    input  logic [hvps_pkg::CFG_W-1:0]  min_ticks,
    input  logic [hvps_pkg::MODE_W-1:0] mode,
    input  logic                        enable,
    input  logic [hvps_pkg::CC_W-1:0]   drive,
    input  logic [TIMER_BITS-1:0]       remaining,
    input  logic                        running,
    output logic [hvps_pkg::MODE_W-1:0] mode_next,
    output logic                        enable_next,
    output logic [hvps_pkg::CC_W-1:0]   drive_next,
    output logic [TIMER_BITS-1:0]       remaining_next,
    output logic                        running_next,
    output logic                        refresh
);

    localparam int LW = (TIMER_BITS > hvps_pkg::CFG_W) ? TIMER_BITS : hvps_pkg::CFG_W;

    logic [LW-1:0]           min_wide;
    logic [LW-1:0]           tmax_wide;
    logic [TIMER_BITS-1:0]   load_ticks;
    logic                    checks_ok;
    logic                    safety_ok;
    logic                    loop_ok;
    logic [hvps_pkg::MODE_W-1:0] fail_mode;
    logic                    enter_req;
    logic [hvps_pkg::MODE_W-1:0] enter_mode;
    logic [TIMER_BITS-1:0]   dec_ticks;

    // Saturate the configured minimum to the timer range
    assign min_wide   = LW'(min_ticks);
    assign tmax_wide  = LW'({TIMER_BITS{1'b1}});
    assign load_ticks = (min_wide > tmax_wide) ? tmax_wide[TIMER_BITS-1:0]
                                               : min_wide[TIMER_BITS-1:0];

    // Check groups, in priority order for the waiting states
    assign safety_ok = status.bms_ok & status.stack_plausible;
    assign loop_ok   = status.insulation_ok & status.disconnects_ok;
    assign checks_ok = safety_ok & loop_ok & status.contactor_power_ok;
    assign fail_mode = !safety_ok ? hvps_pkg::ST_WAIT_SAFETY :
                       !loop_ok   ? hvps_pkg::ST_WAIT_LOOP : hvps_pkg::ST_WAIT_SHUTDOWN;

    assign dec_ticks = (remaining != '0) ? (remaining - TIMER_BITS'(1)) : remaining;

    // Pick the command's transition and the timer and enable updates
    always_comb begin
        enter_req      = 1'b0;
        enter_mode     = mode;
        enable_next    = enable;
        remaining_next = remaining;
        running_next   = running;
        refresh        = 1'b0;
        case (cmd)
            hvps_pkg::CMD_START: begin
                if (mode == hvps_pkg::ST_INIT) begin
                    enter_req  = 1'b1;
                    enter_mode = hvps_pkg::ST_WAIT_SAFETY;
                end
            end
            hvps_pkg::CMD_EVALUATE: begin
                case (mode)
                    hvps_pkg::ST_WAIT_SAFETY, hvps_pkg::ST_WAIT_LOOP,
                    hvps_pkg::ST_WAIT_SHUTDOWN: begin
                        if (enable) begin
                            enter_req  = 1'b1;
                            enter_mode = hvps_pkg::ST_ERROR;
                        end else begin
                            enter_req  = 1'b1;
                            enter_mode = checks_ok ? hvps_pkg::ST_WAIT_ACTIVATION : fail_mode;
                        end
                    end
                    hvps_pkg::ST_WAIT_ACTIVATION: begin
                        if (!checks_ok) begin
                            enter_req  = 1'b1;
                            enter_mode = fail_mode;
                        end else if (enable) begin
                            enter_req  = 1'b1;
                            enter_mode = hvps_pkg::ST_PRECHARGING;
                        end
                    end
                    hvps_pkg::ST_PRECHARGING, hvps_pkg::ST_READY: begin
                        if (!checks_ok) begin
                            enter_req  = 1'b1;
                            enter_mode = hvps_pkg::ST_ERROR;
                        end
                    end
                    hvps_pkg::ST_TIMED: begin
                        enter_req = 1'b1;
                        if (checks_ok && status.precharge_reached
                                && status.precharge_in_range) begin
                            enter_mode = hvps_pkg::ST_READY;
                        end else begin
                            enter_mode = hvps_pkg::ST_ERROR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            hvps_pkg::CMD_FAULT: begin
                refresh = 1'b1;
                if (mode > hvps_pkg::ST_WAIT_SAFETY) begin
                    enter_req  = 1'b1;
                    enter_mode = hvps_pkg::ST_WAIT_SAFETY;
                end
            end
            hvps_pkg::CMD_ENABLE: begin
                if (enable_request != enable) begin
                    enable_next = enable_request;
                    refresh     = 1'b1;
                    if (!enable_request && (mode == hvps_pkg::ST_ERROR
                            || mode >= hvps_pkg::ST_WAIT_SAFETY)) begin
                        enter_req  = 1'b1;
                        enter_mode = hvps_pkg::ST_WAIT_SAFETY;
                    end
                end
            end
            hvps_pkg::CMD_TICK: begin
                if (running) begin
                    remaining_next = dec_ticks;
                    if (dec_ticks == '0) begin
                        running_next = 1'b0;
                        if (mode == hvps_pkg::ST_PRECHARGING) begin
                            enter_req  = 1'b1;
                            enter_mode = hvps_pkg::ST_TIMED;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Apply the side effects of entering the new state
        mode_next  = mode;
        drive_next = drive;
        if (enter_req) begin
            mode_next = enter_mode;
            if (enter_mode <= hvps_pkg::ST_WAIT_ACTIVATION) begin
                drive_next   = hvps_pkg::CC_OPEN;
                running_next = 1'b0;
            end else if (enter_mode == hvps_pkg::ST_PRECHARGING) begin
                drive_next     = hvps_pkg::CC_PRECHARGE;
                remaining_next = load_ticks;
                running_next   = 1'b1;
            end else if (enter_mode == hvps_pkg::ST_READY) begin
                drive_next = hvps_pkg::CC_RUN;
            end
        end
    end

endmodule

/* hdl/hv_precharge_safety_sequencer.sv */
// Top level of the HV precharge safety sequencer: request and result registers,
// sequencer state and config register. Depends on hvps_pkg and hvps_decide.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   request  | s_valid / s_ready    | s_cmd, s_enable_request, seven status bits
//   result   | m_valid / m_ready    | m_sequencer_state, m_contactor_command,
//            |                      | m_refresh_request
//   config   | cfg_wr_en            | cfg_wr_data (precharge_min_ticks)
//
// A request is registered, decided combinationally and its result registered:
// a result passes the request register and then the result register, and one
// request per cycle is sustained while results are taken without a stall.
// Reset (aresetn, synchronous, active low) puts the sequencer in init with
// contactors open and loads the minimum precharge time with 500 ticks.
// A stalled result holds; the request register keeps taking requests until it
// is full behind the stalled result.
module hv_precharge_safety_sequencer #(
    parameter int TIMER_BITS = hvps_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [hvps_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hvps_pkg::CMD_W-1:0]  s_cmd,
    input  logic                        s_enable_request,
    input  logic                        s_bms_ok,
    input  logic                        s_stack_plausible,
    input  logic                        s_insulation_ok,
    input  logic                        s_disconnects_ok,
    input  logic                        s_contactor_power_ok,
    input  logic                        s_precharge_reached,
    input  logic                        s_precharge_in_range,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hvps_pkg::MODE_W-1:0] m_sequencer_state,
    output logic [hvps_pkg::CC_W-1:0]   m_contactor_command,
    output logic                        m_refresh_request
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [hvps_pkg::CMD_W-1:0]  in_cmd_reg;
    logic                        in_enable_reg;
    hvps_pkg::status_t           in_status_reg;
    hvps_pkg::status_t           s_status;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [hvps_pkg::MODE_W-1:0] out_state_reg;
    logic [hvps_pkg::CC_W-1:0]   out_cc_reg;
    logic                        out_refresh_reg;

    logic [hvps_pkg::CFG_W-1:0]  min_ticks_reg;
    logic [hvps_pkg::MODE_W-1:0] mode_reg;
    logic [hvps_pkg::MODE_W-1:0] mode_next;
    logic                        enable_reg;
    logic                        enable_next;
    logic [hvps_pkg::CC_W-1:0]   drive_reg;
    logic [hvps_pkg::CC_W-1:0]   drive_next;
    logic [TIMER_BITS-1:0]       remaining_reg;
    logic [TIMER_BITS-1:0]       remaining_next;
    logic                        running_reg;
    logic                        running_next;
    logic                        refresh;

    logic                        advance;
    logic                        s_fire;

    // Handshake: advance when a request waits and the result slot frees up
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign s_fire         = s_valid && s_ready;
    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    assign s_status = '{
        bms_ok:             s_bms_ok,
        stack_plausible:    s_stack_plausible,
        insulation_ok:      s_insulation_ok,
        disconnects_ok:     s_disconnects_ok,
        contactor_power_ok: s_contactor_power_ok,
        precharge_reached:  s_precharge_reached,
        precharge_in_range: s_precharge_in_range
    };

    // Decide the next sequencer state for the registered request
    hvps_decide #(
        .TIMER_BITS(TIMER_BITS)
    ) u_decide (
        .cmd            (in_cmd_reg),
        .enable_request (in_enable_reg),
        .status         (in_status_reg),
        .min_ticks      (min_ticks_reg),
        .mode           (mode_reg),
        .enable         (enable_reg),
        .drive          (drive_reg),
        .remaining      (remaining_reg),
        .running        (running_reg),
        .mode_next      (mode_next),
        .enable_next    (enable_next),
        .drive_next     (drive_next),
        .remaining_next (remaining_next),
        .running_next   (running_next),
        .refresh        (refresh)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_ticks_reg <= hvps_pkg::PRECHARGE_RESET_TICKS;
            mode_reg      <= hvps_pkg::ST_INIT;
            enable_reg    <= 1'b0;
            drive_reg     <= hvps_pkg::CC_OPEN;
            remaining_reg <= '0;
            running_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                min_ticks_reg <= cfg_wr_data;
            end
            if (advance) begin
                mode_reg      <= mode_next;
                enable_reg    <= enable_next;
                drive_reg     <= drive_next;
                remaining_reg <= remaining_next;
                running_reg   <= running_next;
            end
        end
    end

    // Capture the request payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg    <= s_cmd;
            in_enable_reg <= s_enable_request;
            in_status_reg <= s_status;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg   <= mode_next;
            out_cc_reg      <= drive_next;
            out_refresh_reg <= refresh;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_sequencer_state   = out_state_reg;
    assign m_contactor_command = out_cc_reg;
    assign m_refresh_request   = out_refresh_reg;

`ifndef NO_ASSERTIONS
    // Run command only ever goes with the ready state
    a_run_only_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_reg == hvps_pkg::CC_RUN) == (mode_reg == hvps_pkg::ST_READY))
        else $error("run command and ready state disagree");

    // The precharge timer only runs while precharging
    a_timer_in_precharge: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (mode_reg == hvps_pkg::ST_PRECHARGING))
        else $error("precharge timer running outside precharge");

    // Backpressure only when both registers are full and the result is stalled
    a_ready_low_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("request side stalled without cause");

    // Sequencer state only changes when a request advances
    a_state_moves_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(mode_reg))
        else $error("state changed without a request");
`endif

endmodule
